[rtl/core/rot_enc_pkg.sv]
package rot_enc_pkg;

    // request codes
    localparam logic [1:0] REQ_PIN_CHANGE = 2'd0;
    localparam logic [1:0] REQ_BUTTON     = 2'd1;
    localparam logic [1:0] REQ_PRIME      = 2'd2;

    // result kinds
    localparam logic EVENT_ROTATION = 1'b0;
    localparam logic EVENT_BUTTON   = 1'b1;

    // turn directions
    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    // configuration register indexes
    localparam int          CFG_INDEX_BITS       = 1;
    localparam int          CFG_DATA_BITS        = 16;
    localparam logic [0:0]  REG_INVERT_DIRECTION = 1'd0;
    localparam logic [0:0]  REG_HOLD_OFF_TICKS   = 1'd1;
    localparam logic [15:0] HOLD_OFF_RESET       = 16'd50;

    localparam int EVENT_TIME_BITS = 32;

    localparam int STEPS_PER_DETENT_DEFAULT = 4;
    localparam int TIME_BITS_DEFAULT        = 32;

    // quadrature transition table, indexed by {previous pair, new pair}
    function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
        logic signed [1:0] step;
        unique case (idx)
            4'h1, 4'h7, 4'h8, 4'hE: step = 2'sd1;
            4'h2, 4'h4, 4'hB, 4'hD: step = -2'sd1;
            default:                step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

[rtl/core/rotary_encoder_detent_decoder_unit.sv]
// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  ---------------------------------------------
// in        sink       in_valid/in_stall   req_type, phase_a_level, phase_b_level, event_time
// out       source     out_valid/out_stall event_kind, turn_direction
// cfg       sink       cfg_write           cfg_index, cfg_data
//
// One word per clock in both directions while the result register is not
// stalled; a word passes the input register, then the result register.
// The table lookup, accumulate and hold-off compare run combinationally
// between those two registers.
// in_stall rises only while the input register holds a word and the result
// register is full and stalled.
// Reset clears the quadrature pair, accumulator, press time and registers
// to their defaults; no clearing pass follows.
module rotary_encoder_detent_decoder_unit
    import rot_enc_pkg::*;
#(
    parameter int STEPS_PER_DETENT = STEPS_PER_DETENT_DEFAULT,
    parameter int TIME_BITS        = TIME_BITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic                       phase_a_level,
    input  logic                       phase_b_level,
    input  logic [EVENT_TIME_BITS-1:0] event_time,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       event_kind,
    output logic                       turn_direction,

    input  logic                       cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int ACC_BITS = $clog2(STEPS_PER_DETENT) + 1;
    localparam int SUM_BITS = ACC_BITS + 1;

    localparam logic signed [SUM_BITS-1:0] DETENT_POS = SUM_BITS'(STEPS_PER_DETENT);
    localparam logic signed [SUM_BITS-1:0] DETENT_NEG = -DETENT_POS;

    // configuration
    logic                     invert_reg;
    logic [CFG_DATA_BITS-1:0] hold_off_reg;

    // input register
    logic                       stage_valid_reg, stage_valid_next;
    logic [1:0]                 stage_req_reg;
    logic [1:0]                 stage_pair_reg;
    logic [EVENT_TIME_BITS-1:0] stage_time_reg;

    // decoder state
    logic [1:0]                 prev_pair_reg, prev_pair_next;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;
    logic [TIME_BITS-1:0]       last_press_reg, last_press_next;

    // result register
    logic out_valid_reg, out_valid_next;
    logic event_kind_reg, event_kind_next;
    logic turn_dir_reg, turn_dir_next;

    logic                       slot_free;
    logic                       advance;
    logic                       in_take;
    logic signed [1:0]          step;
    logic signed [SUM_BITS-1:0] sum;
    logic [TIME_BITS-1:0]       now;
    logic [TIME_BITS-1:0]       elapsed;
    logic                       hit;
    logic                       hit_kind;
    logic                       hit_dir;

    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = stage_valid_reg && slot_free;
    assign in_stall  = stage_valid_reg && !slot_free;
    assign in_take   = in_valid && !in_stall;

    assign out_valid      = out_valid_reg;
    assign event_kind     = event_kind_reg;
    assign turn_direction = turn_dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg   <= 1'b0;
            hold_off_reg <= HOLD_OFF_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INVERT_DIRECTION: invert_reg   <= cfg_data[0];
                REG_HOLD_OFF_TICKS:   hold_off_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // input stage
    assign stage_valid_next = in_stall ? stage_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_req_reg  <= req_type;
            stage_pair_reg <= {phase_a_level, phase_b_level};
            stage_time_reg <= event_time;
        end
    end

    // decode
    always_comb
    begin
        step    = step_lookup({prev_pair_reg, stage_pair_reg});
        sum     = SUM_BITS'(acc_reg) + SUM_BITS'(step);
        now     = TIME_BITS'(stage_time_reg);
        elapsed = now - last_press_reg;

        prev_pair_next  = prev_pair_reg;
        acc_next        = acc_reg;
        last_press_next = last_press_reg;
        hit             = 1'b0;
        hit_kind        = EVENT_ROTATION;
        hit_dir         = DIR_CW;

        case (stage_req_reg)
            REQ_PIN_CHANGE:
            begin
                if (stage_pair_reg != prev_pair_reg)
                begin
                    prev_pair_next = stage_pair_reg;
                    if (step != 2'sd0)
                    begin
                        if (sum >= DETENT_POS || sum <= DETENT_NEG)
                        begin
                            acc_next = '0;
                            hit      = 1'b1;
                            hit_dir  = (sum < 0 ? DIR_CCW : DIR_CW) ^ invert_reg;
                        end
                        else
                            acc_next = ACC_BITS'(sum);
                    end
                end
            end
            REQ_BUTTON:
            begin
                if (elapsed >= TIME_BITS'(hold_off_reg))
                begin
                    last_press_next = now;
                    hit             = 1'b1;
                    hit_kind        = EVENT_BUTTON;
                end
            end
            REQ_PRIME:
            begin
                prev_pair_next = stage_pair_reg;
                acc_next       = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pair_reg  <= '0;
            acc_reg        <= '0;
            last_press_reg <= '0;
        end
        else if (advance)
        begin
            prev_pair_reg  <= prev_pair_next;
            acc_reg        <= acc_next;
            last_press_reg <= last_press_next;
        end
    end

    // result register: load when the slot is free, hold while stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        event_kind_next = event_kind_reg;
        turn_dir_next   = turn_dir_reg;
        if (slot_free)
        begin
            out_valid_next  = advance && hit;
            event_kind_next = hit_kind;
            turn_dir_next   = hit_dir;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        event_kind_reg <= event_kind_next;
        turn_dir_reg   <= turn_dir_next;
    end

    // checks
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_BITS'(acc_reg) < DETENT_POS) && (SUM_BITS'(acc_reg) > DETENT_NEG))
        else $error("accumulator left detent range");

    a_button_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_kind_reg == EVENT_BUTTON) |-> (turn_dir_reg == DIR_CW))
        else $error("button word carries a direction");

    a_same_pair_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_req_reg == REQ_PIN_CHANGE && stage_pair_reg == prev_pair_reg)
        |=> !out_valid_reg)
        else $error("unchanged pair produced a word");

    a_prime_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_req_reg == REQ_PRIME)
        |=> (acc_reg == '0 && !out_valid_reg && prev_pair_reg == $past(stage_pair_reg)))
        else $error("prime did not load pair and clear accumulator");

    a_press_time: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_req_reg == REQ_BUTTON && hit)
        |=> (last_press_reg == $past(now) && out_valid_reg && event_kind_reg == EVENT_BUTTON))
        else $error("accepted press not recorded");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import rot_enc_pkg::*;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         DETENT_STEPS  = 4;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         LONG_HOLD     = 60;
    localparam int         PHASE_WORDS   = 105;
    localparam int         PHASE_COUNT   = 6;
    localparam int         SCRIPT_ROWS   = 25;

    typedef struct packed {
        logic kind;
        logic dir;
    } detent_t;

    typedef struct packed {
        logic [1:0]  req;
        logic        a;
        logic        b;
        logic [31:0] stamp;
        logic        typed;
        logic        emits;
        logic        kind;
        logic        dir;
    } script_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 req_type;
    logic                       phase_a_level;
    logic                       phase_b_level;
    logic [EVENT_TIME_BITS-1:0] event_time;
    logic                       out_valid;
    logic                       out_stall;
    logic                       event_kind;
    logic                       turn_direction;
    logic                       cfg_write;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    // typed expectation that travels with the word on the input side
    logic                       row_typed;
    logic                       row_emits;
    logic                       row_kind;
    logic                       row_dir;

    // decoder state as predicted
    logic [1:0]  pred_pair;
    int          pred_steps;
    logic [31:0] pred_last_press;
    logic        cfg_invert;
    logic [15:0] cfg_hold_off;

    int quad_step [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
    logic [1:0] gray_cycle [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    detent_t     expected_events [$];
    script_row_t detent_script [SCRIPT_ROWS];
    int          mismatches;
    int          idle_cycles;
    bit          quiet;
    bit          long_hold_req;

    rotary_encoder_detent_decoder_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .phase_a_level  (phase_a_level),
        .phase_b_level  (phase_b_level),
        .event_time     (event_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .turn_direction (turn_direction),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void decode_event(input logic [1:0] kind, input logic [1:0] pair,
                                         input logic [31:0] stamp, output bit emits,
                                         output detent_t word);
        int          inc;
        logic [31:0] elapsed;
        emits = 1'b0;
        word  = '{EVENT_ROTATION, DIR_CW};
        case (kind)
            REQ_PIN_CHANGE:
            begin
                if (pair != pred_pair)
                begin
                    inc       = quad_step[{pred_pair, pair}];
                    pred_pair = pair;
                    if (inc != 0)
                    begin
                        pred_steps += inc;
                        if (pred_steps >= DETENT_STEPS || pred_steps <= -DETENT_STEPS)
                        begin
                            word.dir   = ((pred_steps < 0) ^ cfg_invert) ? DIR_CCW : DIR_CW;
                            pred_steps = 0;
                            emits      = 1'b1;
                        end
                    end
                end
            end
            REQ_BUTTON:
            begin
                elapsed = stamp - pred_last_press;
                if (elapsed >= {16'd0, cfg_hold_off})
                begin
                    pred_last_press = stamp;
                    word.kind       = EVENT_BUTTON;
                    emits           = 1'b1;
                end
            end
            REQ_PRIME:
            begin
                pred_pair  = pair;
                pred_steps = 0;
            end
            default:
                ;
        endcase
    endfunction

    // predict on every accepted input word
    always @(posedge clk)
    begin
        bit      emits;
        detent_t word;
        if (rst_n && in_valid && !in_stall)
        begin
            decode_event(req_type, {phase_a_level, phase_b_level}, event_time, emits, word);
            if (row_typed)
            begin
                emits = row_emits;
                word  = '{row_kind, row_dir};
            end
            if (emits)
                expected_events.push_back(word);
        end
    end

    always @(posedge clk)
    begin
        detent_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected word: event_kind %0d, turn_direction %0d",
                       event_kind, turn_direction);
                mismatches++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                    mismatches++;
                end
                if (turn_direction !== want.dir)
                begin
                    $error("turn_direction: expected %0d, got %0d", want.dir, turn_direction);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 16);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_word(input script_row_t row);
        int gap;
        gap = 0;
        if (!quiet && !long_hold_req && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type      <= row.req;
        phase_a_level <= row.a;
        phase_b_level <= row.b;
        event_time    <= row.stamp;
        row_typed     <= row.typed;
        row_emits     <= row.emits;
        row_kind      <= row.kind;
        row_dir       <= row.dir;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // lower valid and wait for every expected word, then let the pipe empty
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input logic invert, input logic [15:0] hold);
        cfg_write <= 1'b1;
        cfg_index <= REG_INVERT_DIRECTION;
        cfg_data  <= {15'd0, invert};
        @(posedge clk);
        cfg_index <= REG_HOLD_OFF_TICKS;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_write    <= 1'b0;
        cfg_invert   = invert;
        cfg_hold_off = hold;
    endtask

    initial
    begin
        script_row_t word;
        logic [1:0]  gen_pos;
        logic [31:0] press_clock;
        bit          cw_walk;
        int          hold;
        int          pick;
        int          roll;
        logic        phase_invert [PHASE_COUNT];
        int          phase_hold [PHASE_COUNT];

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        req_type        = REQ_PIN_CHANGE;
        phase_a_level   = 1'b0;
        phase_b_level   = 1'b0;
        event_time      = '0;
        cfg_write       = 1'b0;
        cfg_index       = REG_INVERT_DIRECTION;
        cfg_data        = '0;
        row_typed       = 1'b0;
        row_emits       = 1'b0;
        row_kind        = EVENT_ROTATION;
        row_dir         = DIR_CW;
        pred_pair       = 2'b00;
        pred_steps      = 0;
        pred_last_press = '0;
        cfg_invert      = 1'b0;
        cfg_hold_off    = HOLD_OFF_RESET;
        mismatches      = 0;
        idle_cycles     = 0;
        quiet           = 1'b0;
        long_hold_req   = 1'b0;

        phase_invert = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_hold   = '{0, 65535, 65535, 0, 0, 50};

        detent_script = '{
            // unchanged pair, early presses, hold-off boundary
            '{REQ_PIN_CHANGE, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_BUTTON,     1'b0, 1'b0, 32'd10,        1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_BUTTON,     1'b0, 1'b0, 32'd50,        1'b1, 1'b1, EVENT_BUTTON,   DIR_CW},
            '{REQ_BUTTON,     1'b0, 1'b0, 32'd99,        1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_BUTTON,     1'b0, 1'b0, 32'd100,       1'b1, 1'b1, EVENT_BUTTON,   DIR_CW},
            // invalid jump, unused code, prime
            '{REQ_PIN_CHANGE, 1'b1, 1'b1, 32'hAAAA5555,  1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_UNUSED,     1'b1, 1'b0, 32'hFFFFFFFF,  1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PRIME,      1'b0, 1'b0, 32'h5555AAAA,  1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            // one clockwise detent
            '{REQ_PIN_CHANGE, 1'b0, 1'b1, 32'd1,         1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b1, 1'b1, 32'd2,         1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b1, 1'b0, 32'd3,         1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b0, 1'b0, 32'd4,         1'b1, 1'b1, EVENT_ROTATION, DIR_CW},
            // one counter-clockwise detent
            '{REQ_PIN_CHANGE, 1'b1, 1'b0, 32'd5,         1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b1, 1'b1, 32'd6,         1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b0, 1'b1, 32'd7,         1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b0, 1'b0, 32'd8,         1'b1, 1'b1, EVENT_ROTATION, DIR_CCW},
            // press time wrapping through zero
            '{REQ_BUTTON,     1'b1, 1'b1, 32'hFFFFFFFF,  1'b1, 1'b1, EVENT_BUTTON,   DIR_CW},
            '{REQ_BUTTON,     1'b0, 1'b0, 32'h00000030,  1'b1, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_BUTTON,     1'b0, 1'b0, 32'h00000031,  1'b1, 1'b1, EVENT_BUTTON,   DIR_CW},
            // bounce back and forth, then prime mid-rotation
            '{REQ_PIN_CHANGE, 1'b0, 1'b1, 32'd9,         1'b0, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b0, 1'b0, 32'd10,        1'b0, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b0, 1'b1, 32'd11,        1'b0, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b1, 1'b1, 32'd12,        1'b0, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PRIME,      1'b1, 1'b0, 32'd13,        1'b0, 1'b0, EVENT_ROTATION, DIR_CW},
            '{REQ_PIN_CHANGE, 1'b0, 1'b0, 32'd14,        1'b0, 1'b0, EVENT_ROTATION, DIR_CW}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
            send_word(detent_script[i]);

        gen_pos     = 2'd0;
        cw_walk     = 1'b1;
        press_clock = 32'd100;

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            hold = (p == 4) ? $urandom_range(1, 300) : phase_hold[p];
            write_settings(phase_invert[p], hold[15:0]);
            quiet = (p == PHASE_COUNT - 1);

            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (p == 0 && k == 30)
                    long_hold_req = 1'b1;
                if (p == 1 && k == 50)
                    drain_results();

                word       = '0;
                word.stamp = $urandom;
                word.a     = 1'($urandom_range(0, 1));
                word.b     = 1'($urandom_range(0, 1));
                pick       = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // walk the gray cycle, with some bounce and some jumps
                    word.req = REQ_PIN_CHANGE;
                    roll     = $urandom_range(0, 99);
                    if (roll < 10)
                        cw_walk = !cw_walk;
                    if (roll < 82)
                        gen_pos = cw_walk ? gen_pos + 2'd1 : gen_pos + 2'd3;
                    else if (roll < 90)
                        gen_pos = gen_pos;
                    else if (roll < 96)
                        gen_pos = gen_pos + 2'd2;
                    else
                        gen_pos = 2'($urandom_range(0, 3));
                    {word.a, word.b} = gray_cycle[gen_pos];
                end
                else if (pick < 85)
                begin
                    // half of the presses land near the hold-off boundary
                    word.req = REQ_BUTTON;
                    roll     = $urandom_range(0, 3);
                    if (roll < 2)
                        press_clock = press_clock + hold + $urandom_range(0, 4) - 2;
                    else if (roll == 2)
                        press_clock = press_clock + $urandom_range(0, 40);
                    else
                        press_clock = $urandom;
                    word.stamp = press_clock;
                end
                else if (pick < 93)
                begin
                    word.req = REQ_PRIME;
                    // the gray order is its own inverse map from pair to position
                    gen_pos  = gray_cycle[{word.a, word.b}];
                end
                else
                    word.req = REQ_UNUSED;
                send_word(word);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
